// ===== sv/ps2mct_pkg.sv =====
// Shared constants and helper functions for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    // Widths of the configuration port and the payload fields.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int SCREEN_W   = 13;
    localparam int CURSOR_SIZE_W = 7;
    localparam int POS_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 14;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 8'd3;

    // Reset values.
    localparam logic [SCREEN_W-1:0]      SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0]      SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [CURSOR_SIZE_W-1:0] CURSOR_WIDTH_RST  = 7'd4;
    localparam logic [CURSOR_SIZE_W-1:0] CURSOR_HEIGHT_RST = 7'd4;
    localparam logic [POS_W-1:0]         POS_RST           = 12'd100;
    localparam logic [POS_W-1:0]         POS_MAX           = 12'd4095;

    // Bit positions inside the first byte of a packet.
    localparam int HEAD_SYNC_BIT = 3;
    localparam int HEAD_XSIGN_BIT = 4;
    localparam int HEAD_YSIGN_BIT = 5;

    // Byte counter positions within a packet.
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;

    // Clamp limit: screen size minus cursor size, held within [0, POS_MAX].
    function automatic logic [POS_W-1:0] clamp_limit(
        input logic [SCREEN_W-1:0]      screen,
        input logic [CURSOR_SIZE_W-1:0] cursor
    );
        logic signed [SUM_W-1:0] diff;
        diff = $signed({1'b0, screen}) - $signed({{(SUM_W-CURSOR_SIZE_W){1'b0}}, cursor});
        if (diff < 0) begin
            return '0;
        end else if (diff > $signed({{(SUM_W-POS_W){1'b0}}, POS_MAX})) begin
            return POS_MAX;
        end else begin
            return diff[POS_W-1:0];
        end
    endfunction

    // Coordinate clamp: below at zero, then above at the limit.
    function automatic logic [POS_W-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [POS_W-1:0]        lim
    );
        if (v < 0) begin
            return '0;
        end else if (v[SUM_W-2:0] >= {1'b0, lim}) begin
            return lim;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

endpackage

// ===== sv/ps2_mouse_cursor_tracker.sv =====
// Top level of the PS/2 mouse cursor tracker: packet gathering, deltas and clamping.
//
//  Channel   Direction  Handshake                 Word
//  input     in         i_valid / o_stall         i_aux_data_flag, i_data_byte
//  result    out        o_valid / i_stall         o_cursor_x, o_cursor_y, o_align_error
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A word is taken into the input register, and from there the short add and
// clamp logic writes the result register; one word is taken every cycle unless
// the input side stalls, and the third mouse byte of a packet writes its result.
// Reset is synchronous and active low; it restores the default screen and cursor
// sizes, puts the cursor at (100, 100) and starts a fresh packet.
// The input side stalls only when a packet-completing word waits in the input
// register while an earlier result is still held by a stalled output.
module ps2_mouse_cursor_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input words.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_aux_data_flag,
    input  logic [ps2mct_pkg::BYTE_W-1:0]       i_data_byte,
    // Result words.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ps2mct_pkg::POS_W-1:0]        o_cursor_x,
    output logic [ps2mct_pkg::POS_W-1:0]        o_cursor_y,
    output logic                                o_align_error,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ps2mct_pkg::*;

    // Configuration registers.
    logic [SCREEN_W-1:0]      r_screen_width;
    logic [SCREEN_W-1:0]      r_screen_height;
    logic [CURSOR_SIZE_W-1:0] r_cursor_width;
    logic [CURSOR_SIZE_W-1:0] r_cursor_height;

    // Input register.
    logic              r_in_valid;
    logic              r_in_flag;
    logic [BYTE_W-1:0] r_in_byte;

    // Packet state.
    logic [1:0]        r_byte_idx;
    logic [BYTE_W-1:0] r_head;
    logic [BYTE_W-1:0] r_dx_low;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;

    // Result register.
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_x;
    logic [POS_W-1:0]  r_out_y;
    logic              r_out_err;

    // Next values and decode.
    logic                    w_completes;
    logic                    w_out_free;
    logic                    w_advance;
    logic                    w_take_in;
    logic                    w_head_ok;
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;
    logic [POS_W-1:0]        w_lim_x;
    logic [POS_W-1:0]        w_lim_y;
    logic [POS_W-1:0]        n_pos_x;
    logic [POS_W-1:0]        n_pos_y;

    assign o_cfg_ready = 1'b1;

    // A mouse byte that arrives once two are stored closes the packet and needs the
    // result register; all other words pass through without one.
    assign w_completes = r_in_valid && r_in_flag && (r_byte_idx > IDX_SECOND);
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && (!w_completes || w_out_free);
    assign o_stall     = r_in_valid && !w_advance;
    assign w_take_in   = i_valid && !o_stall;

    assign w_head_ok = r_head[HEAD_SYNC_BIT];
    assign w_lim_x   = clamp_limit(r_screen_width, r_cursor_width);
    assign w_lim_y   = clamp_limit(r_screen_height, r_cursor_height);

    // The nine-bit deltas take their sign from the first byte; X is added, Y subtracted.
    assign w_sum_x = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_x})
                   + $signed({{(SUM_W-BYTE_W){r_head[HEAD_XSIGN_BIT]}}, r_dx_low});
    assign w_sum_y = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_y})
                   - $signed({{(SUM_W-BYTE_W){r_head[HEAD_YSIGN_BIT]}}, r_in_byte});

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (w_head_ok) begin
            n_pos_x = clamp_coord(w_sum_x, w_lim_x);
            n_pos_y = clamp_coord(w_sum_y, w_lim_y);
        end
    end

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
            r_cursor_width  <= CURSOR_WIDTH_RST;
            r_cursor_height <= CURSOR_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_SCREEN_WIDTH) begin
                r_screen_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_SCREEN_HEIGHT) begin
                r_screen_height <= i_cfg_data;
            end else if (i_cfg_index == CFG_CURSOR_WIDTH) begin
                r_cursor_width <= i_cfg_data[CURSOR_SIZE_W-1:0];
            end else if (i_cfg_index == CFG_CURSOR_HEIGHT) begin
                r_cursor_height <= i_cfg_data[CURSOR_SIZE_W-1:0];
            end
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_flag <= i_aux_data_flag;
            r_in_byte <= i_data_byte;
        end
    end

    // Packet byte counter and cursor position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= IDX_FIRST;
            r_pos_x    <= POS_RST;
            r_pos_y    <= POS_RST;
        end else if (w_advance && r_in_flag) begin
            if (w_completes) begin
                r_byte_idx <= IDX_FIRST;
                r_pos_x    <= n_pos_x;
                r_pos_y    <= n_pos_y;
            end else begin
                r_byte_idx <= r_byte_idx + 2'd1;
            end
        end
    end

    // Stored packet bytes are always written before they are read.
    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_flag && (r_byte_idx == IDX_FIRST)) begin
            r_head <= r_in_byte;
        end
        if (w_advance && r_in_flag && (r_byte_idx == IDX_SECOND)) begin
            r_dx_low <= r_in_byte;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_completes) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_completes) begin
            r_out_x   <= n_pos_x;
            r_out_y   <= n_pos_y;
            r_out_err <= !w_head_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cursor_x    = r_out_x;
    assign o_cursor_y    = r_out_y;
    assign o_align_error = r_out_err;

`ifndef NO_ASSERTIONS
    // A held result always shows the current position, as it only moves with a result.
    a_out_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_x == r_pos_x) && (r_out_y == r_pos_y))
        else $error("held result differs from tracked position");

    // The counter never passes the third byte of a packet.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx != 2'd3)
        else $error("packet byte counter out of range");

    // Back-pressure only arises from a closing byte meeting a stalled full output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_completes && r_out_valid && i_stall)
        else $error("input stalled without a blocked result");

    // A misaligned packet leaves the position untouched.
    a_err_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_completes && !w_head_ok) |=>
            $stable(r_pos_x) && $stable(r_pos_y))
        else $error("misaligned packet moved the cursor");
`endif

endmodule

// ===== bench/ps2_mouse_cursor_tracker_test.sv =====
// Self-checking testbench for the PS/2 mouse cursor tracker, using directed and random words.
module ps2_mouse_cursor_tracker_test;
    import ps2mct_pkg::*;

    // Clock, reset and run-length settings.
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 94;
    // A result leaves the block through its result register once the word that
    // closes its packet is taken; the drain also covers words with no result.
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 200000;

    // One cursor report as the result channel carries it.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             err;
    } t_cursor_report;

    // The scoreboard keeps its own copy of the size registers, the packet
    // framing and the cursor position. Every accepted input word is applied to
    // it, and each completed packet queues the report that the block should send.
    class t_cursor_scoreboard;
        logic [SCREEN_W-1:0]      scr_w;
        logic [SCREEN_W-1:0]      scr_h;
        logic [CURSOR_SIZE_W-1:0] cur_w;
        logic [CURSOR_SIZE_W-1:0] cur_h;
        logic [1:0]          byte_count;
        logic [BYTE_W-1:0]   head_byte;
        logic [BYTE_W-1:0]   x_low;
        logic [POS_W-1:0]    track_x;
        logic [POS_W-1:0]    track_y;
        t_cursor_report      reports_due[$];
        int unsigned         mismatches;
        int unsigned         reports_seen;
        int unsigned         misaligned_seen;

        function new();
            scr_w           = SCREEN_WIDTH_RST;
            scr_h           = SCREEN_HEIGHT_RST;
            cur_w           = CURSOR_WIDTH_RST;
            cur_h           = CURSOR_HEIGHT_RST;
            byte_count      = IDX_FIRST;
            head_byte       = '0;
            x_low           = '0;
            track_x         = POS_RST;
            track_y         = POS_RST;
            mismatches      = 0;
            reports_seen    = 0;
            misaligned_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = val;
                CFG_SCREEN_HEIGHT: scr_h = val;
                CFG_CURSOR_WIDTH:  cur_w = val[CURSOR_SIZE_W-1:0];
                CFG_CURSOR_HEIGHT: cur_h = val[CURSOR_SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Highest position that still keeps the whole cursor on the screen.
        function int span_limit(int screen, int cursor);
            int lim;
            lim = screen - cursor;
            if (lim < 0) lim = 0;
            if (lim > int'(POS_MAX)) lim = int'(POS_MAX);
            return lim;
        endfunction

        function logic [POS_W-1:0] pin(int v, int lim);
            if (v < 0) v = 0;
            if (v >= lim) v = lim;
            return POS_W'(v);
        endfunction

        function void note_word(logic flag, logic [BYTE_W-1:0] data);
            int             dx;
            int             dy;
            t_cursor_report rep;
            if (!flag) return;
            case (byte_count)
                IDX_FIRST: begin
                    head_byte  = data;
                    byte_count = IDX_SECOND;
                end
                IDX_SECOND: begin
                    x_low      = data;
                    byte_count = byte_count + 2'd1;
                end
                default: begin
                    byte_count = IDX_FIRST;
                    rep.err    = ~head_byte[HEAD_SYNC_BIT];
                    if (!rep.err) begin
                        dx = int'(x_low) - (head_byte[HEAD_XSIGN_BIT] ? 256 : 0);
                        dy = int'(data) - (head_byte[HEAD_YSIGN_BIT] ? 256 : 0);
                        track_x = pin(int'(track_x) + dx,
                                      span_limit(int'(scr_w), int'(cur_w)));
                        track_y = pin(int'(track_y) - dy,
                                      span_limit(int'(scr_h), int'(cur_h)));
                    end
                    rep.x = track_x;
                    rep.y = track_y;
                    reports_due.push_back(rep);
                end
            endcase
        endfunction

        function void check_report(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic err);
            t_cursor_report want;
            if (reports_due.size() == 0) begin
                $error("cursor report with none outstanding: x=%0d y=%0d align_error=%0b",
                       x, y, err);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            reports_seen++;
            if (want.err) misaligned_seen++;
            if (x !== want.x) begin
                $error("cursor_x: expected %0d, actual %0d", want.x, x);
                mismatches++;
            end
            if (y !== want.y) begin
                $error("cursor_y: expected %0d, actual %0d", want.y, y);
                mismatches++;
            end
            if (err !== want.err) begin
                $error("align_error: expected %0b, actual %0b", want.err, err);
                mismatches++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_aux_data_flag;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [POS_W-1:0]      o_cursor_x;
    logic [POS_W-1:0]      o_cursor_y;
    logic                  o_align_error;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_cursor_scoreboard sb;

    // While calm is set neither side idles, so the block runs at full rate.
    // The main sequence raises long_hold to ask the receiver for one long stall.
    logic        calm = 1'b0;
    logic        long_hold = 1'b0;
    int          drift_x;
    int          drift_y;
    int unsigned mouse_words = 0;
    int unsigned other_words = 0;
    int unsigned cfg_writes = 0;
    int unsigned cycle_count = 0;

    ps2_mouse_cursor_tracker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_aux_data_flag (i_aux_data_flag),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_align_error   (o_align_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog. If the block hangs, the run ends here with a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ps2_mouse_cursor_tracker_test NOT OK");
            $finish;
        end
    end

    // Result monitor. A report is taken at a rising edge where valid is high and
    // stall is low. Both signals are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_report(o_cursor_x, o_cursor_y, o_align_error);
        end
    end

    // Receiver. Before each report it may stall at random, except while calm is set. On
    // request it also holds stall high for one long stretch, counted here, so
    // that the block backs up and stalls its input side.
    initial begin : receiver
        int gap;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
                long_hold = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && !i_stall) && !long_hold);
        end
    end

    // Offers one input word after a random idle gap (none while calm is set),
    // then holds it steady until the block accepts it. Valid is left high after
    // acceptance, so a word that follows with no gap goes out back to back.
    task automatic send_word(input logic flag, input logic [BYTE_W-1:0] data);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_aux_data_flag = flag;
        i_data_byte     = data;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_word(flag, data);
        if (flag) mouse_words++;
        else other_words++;
    endtask

    // Sends three mouse bytes. Outside calm stretches, a keyboard byte now and
    // then goes in ahead of any of them, and the block must ignore it.
    task automatic send_packet(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] xb,
                               input logic [BYTE_W-1:0] yb);
        logic [BYTE_W-1:0] pkt [3];
        pkt[0] = head;
        pkt[1] = xb;
        pkt[2] = yb;
        for (int k = 0; k < 3; k++) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
                send_word(1'b0, BYTE_W'($urandom_range(0, 255)));
            end
            send_word(1'b1, pkt[k]);
        end
    endtask

    // Draws a 9-bit delta. About half of them are large steps in the drift
    // direction of the current phase, which drives the cursor into the clamps.
    function automatic logic [8:0] pick_delta(input int drift);
        int v;
        if (drift != 0 && $urandom_range(0, 1) == 1) begin
            v = int'($urandom_range(200, 255));
            if (drift < 0) v = -v - 1;
        end else begin
            v = int'($urandom_range(0, 511)) - 256;
        end
        return 9'(v);
    endfunction

    // Sends a well-formed packet. If a stray byte has left the framing part
    // way through a packet, filler bytes first finish that packet off.
    task automatic good_packet();
        logic [8:0]        dx;
        logic [8:0]        dy;
        logic [BYTE_W-1:0] head;
        while (sb.byte_count != IDX_FIRST) send_word(1'b1, BYTE_W'($urandom_range(0, 255)));
        dx   = pick_delta(drift_x);
        dy   = pick_delta(drift_y);
        head = BYTE_W'($urandom_range(0, 255));
        head[HEAD_SYNC_BIT]  = 1'b1;
        head[HEAD_XSIGN_BIT] = dx[8];
        head[HEAD_YSIGN_BIT] = dy[8];
        send_packet(head, dx[7:0], dy[7:0]);
    endtask

    // Lowers valid, waits for every outstanding report and then lets the
    // pipeline empty. The block is idle once this returns.
    task automatic quiesce();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sizes(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                             input logic [CFG_DATA_W-1:0] cw, input logic [CFG_DATA_W-1:0] ch);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_CURSOR_WIDTH, cw);
        write_reg(CFG_CURSOR_HEIGHT, ch);
    endtask

    initial begin : stimulus
        int unsigned start;
        int          pick;
        logic [BYTE_W-1:0] head;

        sb              = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_aux_data_flag = 1'b0;
        i_data_byte     = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        drift_x         = 0;
        drift_y         = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words, run with the reset screen and cursor sizes.
        // A keyboard byte with every bit set must be ignored.
        send_word(1'b0, 8'hFF);
        // A positive dX of 127 with no Y movement.
        send_word(1'b1, 8'h08);
        send_word(1'b1, 8'h7F);
        send_word(1'b1, 8'h00);
        // A negative dX, with a keyboard byte inside the packet. The large
        // positive dY pulls Y below zero, so Y clamps at the top edge.
        send_word(1'b1, 8'h18);
        send_word(1'b0, 8'hAA);
        send_word(1'b1, 8'h80);
        send_word(1'b1, 8'hFF);
        // The first byte lacks the sync bit, so the position must be kept.
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'h12);
        send_word(1'b1, 8'h34);
        // Both deltas at their most negative value.
        send_word(1'b1, 8'h38);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'h00);
        // Largest positive dX and a dY of minus 255.
        send_word(1'b1, 8'h28);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h01);
        // Every header bit is set except the sync bit.
        send_word(1'b1, 8'hF7);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'h00);
        // All bytes are 0xFF, which gives a step of minus one on both axes.
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'hFF);

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only while the block is idle.
            quiesce();
            case (p)
                0: set_sizes(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST,
                             CURSOR_WIDTH_RST, CURSOR_HEIGHT_RST);
                1: set_sizes(13'd8, 13'd8, 13'd1, 13'd1);
                // The cursor is larger than the screen, so both limits drop to zero.
                2: set_sizes(13'd8, 13'd8, 13'd64, 13'd64);
                3: set_sizes(13'd4096, 13'd4096, 13'd1, 13'd1);
                // Out-of-range sizes: the limit saturates at the top and the
                // cursor size is zero. A write to an unknown index must be ignored.
                4: begin
                    set_sizes(13'h1FFF, 13'h1FFF, 13'd0, 13'd0);
                    write_reg(CFG_IDX_W'($urandom_range(4, 255)),
                              CFG_DATA_W'($urandom_range(0, 8191)));
                end
                5: set_sizes(13'd640, 13'd480, 13'd127, 13'd7);
                6: set_sizes(CFG_DATA_W'($urandom_range(8, 4096)),
                             CFG_DATA_W'($urandom_range(8, 4096)),
                             CFG_DATA_W'($urandom_range(1, 64)),
                             CFG_DATA_W'($urandom_range(1, 64)));
                default: begin
                    write_reg(CFG_IDX_W'($urandom_range(4, 255)),
                              CFG_DATA_W'($urandom_range(0, 8191)));
                    set_sizes(CFG_DATA_W'($urandom_range(0, 8191)),
                              CFG_DATA_W'($urandom_range(0, 8191)),
                              CFG_DATA_W'($urandom_range(0, 127)),
                              CFG_DATA_W'($urandom_range(0, 127)));
                end
            endcase
            calm    = (p == 1 || p == 5);
            drift_x = $urandom_range(0, 1) ? 1 : -1;
            drift_y = $urandom_range(0, 1) ? 1 : -1;
            start   = mouse_words;

            // Back pressure: the receiver holds off for a long stretch while
            // packets go in back to back. The sender then waits until every
            // report has come back out.
            if (p == 3) begin
                calm      = 1'b1;
                long_hold = 1'b1;
                repeat (6) good_packet();
                calm = 1'b0;
                quiesce();
            end

            while (mouse_words - start < WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) begin
                    good_packet();
                end else if (pick < 18) begin
                    // A misaligned packet, with the sync bit clear in its first byte.
                    head = BYTE_W'($urandom_range(0, 255));
                    head[HEAD_SYNC_BIT] = 1'b0;
                    send_packet(head, BYTE_W'($urandom_range(0, 255)),
                                BYTE_W'($urandom_range(0, 255)));
                end else begin
                    // A stray mouse byte that shifts the packet framing.
                    send_word(1'b1, BYTE_W'($urandom_range(0, 255)));
                end
            end
        end

        quiesce();
        $display("Sent %0d mouse words and %0d keyboard words over %0d register writes.",
                 mouse_words, other_words, cfg_writes);
        $display("Checked %0d cursor reports, %0d of them from misaligned packets.",
                 sb.reports_seen, sb.misaligned_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ps2_mouse_cursor_tracker_test OK");
        end else begin
            $display("ps2_mouse_cursor_tracker_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== ps2_mouse_cursor_tracker.f =====
sv/ps2mct_pkg.sv
sv/ps2_mouse_cursor_tracker.sv
bench/ps2_mouse_cursor_tracker_test.sv
